// ----- rtl/core/oets_pkg.sv -----
// package of the odd-even transposition sorter: item types, fsm states, control structs
`timescale 1ns / 1ps
`default_nettype none

package oets_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned DefCapacity = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    set_end;
  } oets_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    final_result;
    logic                    overflowed;
  } oets_out_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_DRAIN
  } oets_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;        // input item accepted
    logic phase_step;  // run one transposition phase
    logic shift;       // result item accepted, advance the store
  } oets_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sort_last;   // current phase is the final one
    logic last_out;    // head of store is the last element of the set
  } oets_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/odd_even_transposition_sorter.sv -----
// top level of the odd-even transposition sorter
`timescale 1ns / 1ps
`default_nettype none

// odd-even transposition sorter: signed 32-bit input items are collected, one per cycle,
// into a store of CAPACITY entries until an item with set_end arrives; items that find
// the store full are dropped and every result of that set then shows overflowed. the
// set_end item starts the sort: n transposition phases (n = elements stored), one phase
// per cycle, each phase running all compare-swap lanes of one parity in parallel. the
// set then leaves in ascending order, one result item per cycle while out_ready_i is
// high, final_result marking the last one. no input item is taken from the set_end item
// until the last result of the set is accepted. a single row of compare-swap lanes
// serves every phase.

module odd_even_transposition_sorter #(
  parameter int unsigned CAPACITY = oets_pkg::DefCapacity
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input items
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire oets_pkg::oets_in_t  in_data_i,
  // result items
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output oets_pkg::oets_out_t      out_data_o
);
  import oets_pkg::*;

  oets_cmd_t    cmd;
  oets_status_t status;

  // sequencing: load, sort phases, drain
  oets_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_set_end_i (in_data_i.set_end),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // store, compare-swap lanes and counters; results come straight from the store head
  oets_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/oets_ctrl.sv -----
// controller state machine of the odd-even transposition sorter
`timescale 1ns / 1ps
`default_nettype none

module oets_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_set_end_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire oets_pkg::oets_status_t status_i,
  output oets_pkg::oets_cmd_t        cmd_o
);
  import oets_pkg::*;

  oets_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_set_end_i) begin
          state_d = ST_SORT;
        end
      end
      ST_SORT: begin
        if (status_i.sort_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_ready_i && status_i.last_out) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    cmd_o.load       = 1'b0;
    cmd_o.phase_step = 1'b0;
    cmd_o.shift      = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SORT: begin
        cmd_o.phase_step = 1'b1;
      end
      ST_DRAIN: begin
        out_valid_o = 1'b1;
        cmd_o.shift = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/oets_datapath.sv -----
// element store, compare-swap lanes and counters of the sorter; results come from the store head
`timescale 1ns / 1ps
`default_nettype none

module oets_datapath #(
  parameter int unsigned CAPACITY = oets_pkg::DefCapacity
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire oets_pkg::oets_in_t     in_data_i,
  input  wire oets_pkg::oets_cmd_t    cmd_i,
  output oets_pkg::oets_status_t      status_o,
  output oets_pkg::oets_out_t         out_data_o
);
  import oets_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic signed [DataW-1:0] store_q [CAPACITY];
  logic signed [DataW-1:0] store_d [CAPACITY];
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] phase_q, phase_d;
  logic            ovf_q, ovf_d;
  logic            full;

  assign full = (count_q == CapCnt);

  assign status_o.sort_last = ((phase_q + CntW'(1)) == count_q);
  assign status_o.last_out  = (count_q == CntW'(1));

  assign out_data_o.sorted_value = store_q[0];
  assign out_data_o.final_result = status_o.last_out;
  assign out_data_o.overflowed   = ovf_q;

  // store next value: load write, one phase of lanes, or shift toward the head
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      store_d[i] = store_q[i];
    end
    if (cmd_i.load && !full) begin
      store_d[count_q[IdxW-1:0]] = in_data_i.value;
    end
    if (cmd_i.phase_step) begin
      // pairs of one parity are disjoint, lanes only inside the set
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if ((i % 2) == int'(phase_q[0]) && (CntW'(i + 1) < count_q)) begin
          if (store_q[i] > store_q[i+1]) begin
            store_d[i]   = store_q[i+1];
            store_d[i+1] = store_q[i];
          end
        end
      end
    end
    if (cmd_i.shift) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        store_d[i] = store_q[i+1];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    phase_d = phase_q;
    ovf_d   = ovf_q;
    if (cmd_i.load) begin
      phase_d = '0;
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
    if (cmd_i.phase_step) begin
      phase_d = phase_q + CntW'(1);
    end
    if (cmd_i.shift) begin
      count_d = count_q - CntW'(1);
      if (status_o.last_out) begin
        ovf_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      store_q[i] <= store_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      phase_q <= phase_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/oets_checker.sv -----
// port-level checker of the odd-even transposition sorter and its bind
`timescale 1ns / 1ps
`default_nettype none

module oets_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire oets_pkg::oets_in_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire oets_pkg::oets_out_t out_data_o
);
  import oets_pkg::*;

  // loading and draining never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");

  // set_end item closes the input side
  a_close_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.set_end) |=> !in_ready_o)
    else $error("input still open after set end");

  // final result ends the drain
  a_final_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.final_result) |=> !out_valid_o)
    else $error("results continue after final");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind odd_even_transposition_sorter oets_checker u_oets_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- tb/sv/tb_odd_even_transposition_sorter.sv -----
// self-checking testbench of the odd-even transposition sorter
`timescale 1ns / 1ps

module tb_odd_even_transposition_sorter;
  import oets_pkg::*;

  localparam int unsigned CAP        = DefCapacity;
  localparam int unsigned CYCLE_CAP  = 200000;  // run is far shorter when correct
  localparam int unsigned SETTLE_CYC = 3 * CAP + 20;
  localparam int unsigned ITEM_GOAL  = 330;

  // shapes of a generated set
  typedef enum int unsigned {
    SHAPE_RANDOM,
    SHAPE_FALLING,
    SHAPE_RISING
  } set_shape_e;

  logic      clk;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  oets_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  oets_out_t out_data;

  // predictor state: the set being collected
  logic signed [DataW-1:0] held_vals [CAP];
  int unsigned             held_cnt;
  logic                    held_ovf;
  // results still owed by the block, oldest first
  oets_out_t               sorted_q [$];

  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned items_sent;
  bit          tx_quiet;     // sender never idles while set
  bit          rx_quiet;     // receiver never idles while set
  int unsigned rx_hold_req;  // request for a long receiver hold-off
  int unsigned rx_hold_left;

  odd_even_transposition_sorter #(
    .CAPACITY(CAP)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // global watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("tb_odd_even_transposition_sorter NOT OK");
      $finish;
    end
  end

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  // predictor: collect one item, on set_end sort the set by odd-even
  // transposition and queue one result per stored element
  task automatic absorb_item(input oets_in_t it);
    oets_out_t               res;
    logic signed [DataW-1:0] tmp;
    if (held_cnt < CAP) begin
      held_vals[held_cnt] = it.value;
      held_cnt++;
    end else begin
      // store full: element dropped, set_end still honored below
      held_ovf = 1'b1;
    end
    if (it.set_end) begin
      // one phase per element, even pairs first, then alternating parity
      for (int p = 0; p < held_cnt; p++) begin
        for (int j = p % 2; j + 1 < held_cnt; j += 2) begin
          if (held_vals[j] > held_vals[j+1]) begin
            tmp            = held_vals[j];
            held_vals[j]   = held_vals[j+1];
            held_vals[j+1] = tmp;
          end
        end
      end
      for (int k = 0; k < held_cnt; k++) begin
        res.sorted_value = held_vals[k];
        res.final_result = (k == held_cnt - 1);
        res.overflowed   = held_ovf;
        sorted_q.push_back(res);
      end
      held_cnt = 0;
      held_ovf = 1'b0;
    end
  endtask

  // every accepted input item feeds the predictor
  always @(posedge clk) begin
    if (rst_ni && in_valid && in_ready) absorb_item(in_data);
  end

  // every accepted result is matched against the oldest expectation
  always @(posedge clk) begin
    oets_out_t exp_res;
    if (rst_ni && out_valid && out_ready) begin
      if (sorted_q.size() == 0) begin
        note_error($sformatf("unexpected result: value %0d final %0b ovf %0b",
                             out_data.sorted_value, out_data.final_result,
                             out_data.overflowed));
      end else begin
        exp_res = sorted_q.pop_front();
        if (out_data.sorted_value !== exp_res.sorted_value ||
            out_data.final_result !== exp_res.final_result ||
            out_data.overflowed !== exp_res.overflowed) begin
          note_error($sformatf(
            "mismatch: expected value %0d final %0b ovf %0b, got value %0d final %0b ovf %0b",
            exp_res.sorted_value, exp_res.final_result, exp_res.overflowed,
            out_data.sorted_value, out_data.final_result, out_data.overflowed));
        end
      end
    end
  end

  // receiver: random stalls, quiet stretches, and long hold-offs on request
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rx_quiet || ($urandom_range(0, 99) >= 14);
    end
  end

  // offer one item, with an occasional random gap first; returns at the
  // edge where the item is taken
  task automatic send_item(input logic signed [DataW-1:0] val, input logic last);
    oets_in_t it;
    while (!tx_quiet && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.value   = val;
    it.set_end = last;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // mostly full-range values, some tiny ones for duplicates, some extremes
  function automatic logic signed [DataW-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom;
    if (sel < 8) return $signed($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh8000_0001;
      3: return 32'sh7fff_fffe;
      4: return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  task automatic send_set(input int unsigned n, input set_shape_e shape);
    logic signed [DataW-1:0] val;
    logic signed [DataW-1:0] step;
    val  = pick_value();
    step = $urandom_range(1, 5000);
    for (int k = 0; k < n; k++) begin
      send_item((shape == SHAPE_RANDOM) ? pick_value() : val, k == n - 1);
      if (shape == SHAPE_FALLING) val = val - step;
      else if (shape == SHAPE_RISING) val = val + step;
    end
  endtask

  // stop offering and wait until every owed result has come back; it first waits
  // for a clock edge so the predictor has taken the last accepted item
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  // edge values, duplicates, single-element set, reversed order
  task automatic test_directed();
    // one-element set
    send_item(32'sh8000_0000, 1'b1);
    // both extremes of the signed range around zero
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd1, 1'b1);
    // equal values are never swapped
    send_item(32'sd5, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(32'sd5, 1'b1);
    // fully reversed set needs every phase
    for (int k = 0; k < 8; k++) send_item(32'sd100 - k * 7, k == 7);
  endtask

  // store full: extra elements, the set_end one too, are dropped
  task automatic test_overflow();
    send_set(CAP + 1, SHAPE_FALLING);
    // count and overflow flag must be clear again
    send_set(2, SHAPE_RANDOM);
    send_set(CAP + 6, SHAPE_RANDOM);
    send_set(CAP, SHAPE_FALLING);
  endtask

  // mostly small sets, some mid-size, a few past capacity
  task automatic test_random_sets(input int unsigned goal);
    int unsigned pick;
    int unsigned n;
    set_shape_e  shape;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) n = $urandom_range(1, 6);
      else if (pick < 92) n = $urandom_range(7, CAP);
      else n = $urandom_range(CAP + 1, CAP + 8);
      case ($urandom_range(0, 3))
        0: shape = SHAPE_FALLING;
        1: shape = SHAPE_RISING;
        default: shape = SHAPE_RANDOM;
      endcase
      send_set(n, shape);
    end
  endtask

  // receiver holds off long enough that the block fills and stops taking
  // items while the sender keeps offering the next set
  task automatic test_backpressure();
    rx_hold_req = 4 * CAP + 200;
    send_set(CAP, SHAPE_FALLING);
    send_set(5, SHAPE_RANDOM);
    send_set(3, SHAPE_RISING);
  endtask

  // sender goes silent until the block has handed back everything
  task automatic test_pause();
    send_set(6, SHAPE_RANDOM);
    wait_drained();
    send_set(4, SHAPE_FALLING);
  endtask

  initial begin
    rst_ni       <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    out_ready    <= 1'b0;
    held_cnt     = 0;
    held_ovf     = 1'b0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    items_sent   = 0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    rx_hold_req  = 0;
    rx_hold_left = 0;
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_directed();
    test_overflow();
    test_random_sets(170);
    // long stretch with neither side idling
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    test_random_sets(240);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    test_backpressure();
    test_pause();
    test_random_sets(ITEM_GOAL);

    // let every owed result out, then watch for strays
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (err_cnt == 0 && sorted_q.size() == 0) begin
      $display("tb_odd_even_transposition_sorter OK");
    end else begin
      $display("tb_odd_even_transposition_sorter NOT OK");
    end
    $finish;
  end

endmodule
